[rtl/wpa_pkg.sv]
// Shared types, codes and reset values for the worker pool autoscaler.
`timescale 1ns / 1ps

package wpa_pkg;

  // Default widths
  localparam int DEF_TIME_BITS   = 48;
  localparam int DEF_DEPTH_BITS  = 16;
  localparam int DEF_WORKER_BITS = 8;

  // Configuration register indexes
  localparam int CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LOAD_FACTOR       = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BUSY_WORKERS      = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_WORKERS       = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDLE_WORKERS      = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDLE_TIMEOUT      = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RAMP_UP_HOLDOFF   = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RAMP_DOWN_HOLDOFF = 3'd6;

  // Register reset values, truncated to field width where used
  localparam logic [63:0] RST_LOAD_FACTOR       = 64'd4;
  localparam logic [63:0] RST_BUSY_WORKERS      = 64'd4;
  localparam logic [63:0] RST_MAX_WORKERS       = 64'd16;
  localparam logic [63:0] RST_IDLE_WORKERS      = 64'd1;
  localparam logic [63:0] RST_IDLE_TIMEOUT      = 64'd1000000;
  localparam logic [63:0] RST_RAMP_UP_HOLDOFF   = 64'd1000;
  localparam logic [63:0] RST_RAMP_DOWN_HOLDOFF = 64'd100000;

  // Pool action codes
  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_ADD    = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;     // capture the input word
    logic start_load;  // start depth / workers division
    logic start_ovr;   // start overload division
    logic mul;         // register load, product and time compares
    logic commit;      // write result word and update tracking state
  } wpa_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_busy;
    logic need_div2;
  } wpa_sts_t;

endpackage

[rtl/worker_pool_autoscaler_core.sv]
// Top level of the worker pool autoscaler.
`timescale 1ns / 1ps
//
// Worker pool autoscaler core.
// Input channel (in_valid/in_ready) takes one word per manager tick: now_time,
// queue_depth, worker_count. Output channel (out_valid/out_ready) returns one
// word per input: target_workers, pool_action (none/add/remove), idle_applied.
// Config port: cfg_we writes cfg_data into register cfg_index the same edge;
// write only while no word is in flight. Unused indexes are ignored.
// Flow: one word in flight. The depth/worker division yields DEPTH_BITS
// quotient bits, the overload division (only when load exceeds load_factor and
// load_factor is nonzero) DEPTH_BITS+WORKER_BITS bits, both on one shared
// restoring divider.
// in_ready is high only between words; the next word can be taken the cycle
// after the result is registered, even if that result still waits.
// Stalls: if out_ready is low, a finished word waits in the output register;
// a following result holds in the datapath until the slot frees.
// Reset (rst, sync, active high) loads the register defaults, marks the queue
// idle and clears tracking times and out_valid.
//

module worker_pool_autoscaler_core import wpa_pkg::*; #(
  parameter int TIME_BITS   = DEF_TIME_BITS,
  parameter int DEPTH_BITS  = DEF_DEPTH_BITS,
  parameter int WORKER_BITS = DEF_WORKER_BITS,
  localparam int CFG_BITS =
    (TIME_BITS >= DEPTH_BITS) ? ((TIME_BITS >= WORKER_BITS) ? TIME_BITS : WORKER_BITS)
                              : ((DEPTH_BITS >= WORKER_BITS) ? DEPTH_BITS : WORKER_BITS)
) (
  input  logic                    clk,
  input  logic                    rst,
  // configuration
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data,
  // tick word
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [TIME_BITS-1:0]    now_time,
  input  logic [DEPTH_BITS-1:0]   queue_depth,
  input  logic [WORKER_BITS-1:0]  worker_count,
  // result word
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [WORKER_BITS-1:0]  target_workers,
  output logic [1:0]              pool_action,
  output logic                    idle_applied
);

  wpa_cmd_t cmd;
  wpa_sts_t sts;

  // Sequencer: accept, load division, overload division when needed, commit
  wpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Config registers, shared divider, target/clamp/holdoff logic, output word
  wpa_dpath #(
    .TIME_BITS   (TIME_BITS),
    .DEPTH_BITS  (DEPTH_BITS),
    .WORKER_BITS (WORKER_BITS),
    .CFG_BITS    (CFG_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .now_time       (now_time),
    .queue_depth    (queue_depth),
    .worker_count   (worker_count),
    .cmd            (cmd),
    .sts            (sts),
    .target_workers (target_workers),
    .pool_action    (pool_action),
    .idle_applied   (idle_applied)
  );

endmodule

[rtl/wpa_ctrl.sv]
// Sequencing state machine of the worker pool autoscaler.
`timescale 1ns / 1ps

module wpa_ctrl import wpa_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  wpa_sts_t sts,
  output wpa_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LD   = 3'd1;
  localparam logic [2:0] S_WL   = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_CK   = 3'd4;
  localparam logic [2:0] S_WO   = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0] state, state_next;
  logic       slot_free;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.load_in    = in_valid && in_ready;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_LD;
      end
      S_LD: begin
        cmd.start_load = 1'b1;
        state_next     = S_WL;
      end
      S_WL: begin
        if (!sts.div_busy) state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_CK;
      end
      S_CK: begin
        if (sts.need_div2) begin
          cmd.start_ovr = 1'b1;
          state_next    = S_WO;
        end else begin
          state_next = S_FIN;
        end
      end
      S_WO: begin
        if (!sts.div_busy) state_next = S_FIN;
      end
      S_FIN: begin
        if (slot_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // A result word never overwrites one still waiting
  a_commit_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("commit while output word pending");

  // An accepted word always starts the load division next
  a_accept_seq: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_LD))
    else $error("accept did not start division");

  // Output valid only rises after a commit
  a_valid_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.commit))
    else $error("output valid without commit");

  // Overload division only starts on an idle divider when needed
  a_ovr_start: assert property (@(posedge clk) disable iff (rst)
    cmd.start_ovr |-> (sts.need_div2 && !sts.div_busy))
    else $error("bad overload division start");

endmodule

[rtl/wpa_dpath.sv]
// Datapath of the worker pool autoscaler: config, divider, target and actions.
`timescale 1ns / 1ps

module wpa_dpath import wpa_pkg::*; #(
  parameter int TIME_BITS   = DEF_TIME_BITS,
  parameter int DEPTH_BITS  = DEF_DEPTH_BITS,
  parameter int WORKER_BITS = DEF_WORKER_BITS,
  parameter int CFG_BITS    = DEF_TIME_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data,
  input  logic [TIME_BITS-1:0]    now_time,
  input  logic [DEPTH_BITS-1:0]   queue_depth,
  input  logic [WORKER_BITS-1:0]  worker_count,
  input  wpa_cmd_t                cmd,
  output wpa_sts_t                sts,
  output logic [WORKER_BITS-1:0]  target_workers,
  output logic [1:0]              pool_action,
  output logic                    idle_applied
);

  localparam int QW = DEPTH_BITS + WORKER_BITS;  // divider width
  localparam int TW = QW + 2;                    // signed target width
  localparam int CW = $clog2(QW + 1);

  // Config registers
  logic [DEPTH_BITS-1:0]  load_factor;
  logic [WORKER_BITS-1:0] busy_workers, max_workers, idle_workers;
  logic [TIME_BITS-1:0]   idle_timeout, ramp_up_holdoff, ramp_down_holdoff;

  // Tracking state
  logic [DEPTH_BITS-1:0]  previous_depth;
  logic [TIME_BITS-1:0]   idle_since, last_change_time;
  logic                   idle_tracking;

  // Captured input word
  logic [TIME_BITS-1:0]   now_r;
  logic [DEPTH_BITS-1:0]  depth_r;
  logic [WORKER_BITS-1:0] workers_r;

  // Divider
  logic [QW-1:0] rem, dq, dvs, rem_next;
  logic [QW:0]   shifted, trial;
  logic [CW-1:0] cnt;
  logic          div_busy, qbit;

  // Product stage
  logic          load_le, lf_zero, depth_nz, need_div2, span_neg;
  logic          idle_gt, up_gt, dn_gt;
  logic [QW-1:0] prod_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      load_factor       <= RST_LOAD_FACTOR[DEPTH_BITS-1:0];
      busy_workers      <= RST_BUSY_WORKERS[WORKER_BITS-1:0];
      max_workers       <= RST_MAX_WORKERS[WORKER_BITS-1:0];
      idle_workers      <= RST_IDLE_WORKERS[WORKER_BITS-1:0];
      idle_timeout      <= RST_IDLE_TIMEOUT[TIME_BITS-1:0];
      ramp_up_holdoff   <= RST_RAMP_UP_HOLDOFF[TIME_BITS-1:0];
      ramp_down_holdoff <= RST_RAMP_DOWN_HOLDOFF[TIME_BITS-1:0];
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LOAD_FACTOR:       load_factor       <= cfg_data[DEPTH_BITS-1:0];
        CFG_BUSY_WORKERS:      busy_workers      <= cfg_data[WORKER_BITS-1:0];
        CFG_MAX_WORKERS:       max_workers       <= cfg_data[WORKER_BITS-1:0];
        CFG_IDLE_WORKERS:      idle_workers      <= cfg_data[WORKER_BITS-1:0];
        CFG_IDLE_TIMEOUT:      idle_timeout      <= cfg_data[TIME_BITS-1:0];
        CFG_RAMP_UP_HOLDOFF:   ramp_up_holdoff   <= cfg_data[TIME_BITS-1:0];
        CFG_RAMP_DOWN_HOLDOFF: ramp_down_holdoff <= cfg_data[TIME_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      now_r     <= now_time;
      depth_r   <= queue_depth;
      workers_r <= worker_count;
    end
  end

  // Restoring divider, one quotient bit per cycle
  assign shifted  = {rem, dq[QW-1]};
  assign trial    = shifted - {1'b0, dvs};
  assign qbit     = !trial[QW];
  assign rem_next = qbit ? trial[QW-1:0] : shifted[QW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
    end else if (cmd.start_load || cmd.start_ovr) begin
      div_busy <= 1'b1;
    end else if (div_busy && cnt == CW'(1)) begin
      div_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_load) begin
      // depth left-aligned: quotient lands in the low DEPTH_BITS
      rem <= '0;
      dq  <= {depth_r, {WORKER_BITS{1'b0}}};
      dvs <= QW'(workers_r);
      cnt <= CW'(DEPTH_BITS);
    end else if (cmd.start_ovr) begin
      rem <= '0;
      dq  <= prod_mag;
      dvs <= QW'(load_factor);
      cnt <= CW'(QW);
    end else if (div_busy) begin
      rem <= rem_next;
      dq  <= {dq[QW-2:0], qbit};
      cnt <= cnt - CW'(1);
    end
  end

  assign sts.div_busy  = div_busy;
  assign sts.need_div2 = need_div2;

  // Load, overload product and elapsed-time compares
  logic [DEPTH_BITS-1:0]  load_val, over;
  logic [WORKER_BITS:0]   span, span_abs;
  logic [TIME_BITS-1:0]   el_idle, el_change;

  always_comb begin
    load_val  = (workers_r == '0) ? depth_r : dq[DEPTH_BITS-1:0];
    over      = load_val - load_factor;
    span      = {1'b0, max_workers} - {1'b0, busy_workers};
    span_abs  = span[WORKER_BITS] ? (~span + 1'b1) : span;
    el_idle   = now_r - idle_since;
    el_change = now_r - last_change_time;
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      depth_nz  <= (depth_r != '0);
      load_le   <= (load_val <= load_factor);
      lf_zero   <= (load_factor == '0);
      need_div2 <= (depth_r != '0) && (load_val > load_factor) && (load_factor != '0);
      span_neg  <= span[WORKER_BITS];
      prod_mag  <= QW'(span_abs[WORKER_BITS-1:0]) * QW'(over);
      idle_gt   <= (el_idle > idle_timeout);
      up_gt     <= (el_change > ramp_up_holdoff);
      dn_gt     <= (el_change > ramp_down_holdoff);
    end
  end

  // Target selection and clamp
  logic signed [TW-1:0] busy_s, max_s, idle_s, workers_s, q_s;
  logic signed [TW-1:0] tgt_raw, tgt_sel, tgt_lo, tgt_clamp;
  logic                 depth_z, prev_nz, idle_hit;
  logic [1:0]           action;

  always_comb begin
    busy_s    = $signed(TW'(busy_workers));
    max_s     = $signed(TW'(max_workers));
    idle_s    = $signed(TW'(idle_workers));
    workers_s = $signed(TW'(workers_r));
    q_s       = $signed(TW'(dq));
    depth_z   = !depth_nz;
    prev_nz   = (previous_depth != '0);

    tgt_raw = workers_s;
    if (depth_nz) begin
      if (load_le)      tgt_raw = busy_s;
      else if (lf_zero) tgt_raw = max_s;
      else if (span_neg) tgt_raw = busy_s - q_s;  // truncation toward zero
      else              tgt_raw = busy_s + q_s;
    end

    idle_hit = !prev_nz && depth_z && idle_tracking && idle_gt;
    tgt_sel  = idle_hit ? idle_s : tgt_raw;

    // raise to idle first, then cap at max
    tgt_lo    = (tgt_sel < idle_s) ? idle_s : tgt_sel;
    tgt_clamp = (tgt_lo > max_s) ? max_s : tgt_lo;

    if (tgt_clamp > workers_s && up_gt)      action = ACT_ADD;
    else if (tgt_clamp < workers_s && dn_gt) action = ACT_REMOVE;
    else                                     action = ACT_NONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_depth   <= '0;
      idle_since       <= '0;
      idle_tracking    <= 1'b1;
      last_change_time <= '0;
    end else if (cmd.commit) begin
      previous_depth <= depth_r;
      if (prev_nz && depth_z) begin
        idle_since    <= now_r;
        idle_tracking <= 1'b1;
      end else if (depth_nz) begin
        idle_tracking <= 1'b0;
      end
      if (action != ACT_NONE) last_change_time <= now_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      target_workers <= tgt_clamp[WORKER_BITS-1:0];
      pool_action    <= action;
      idle_applied   <= idle_hit;
    end
  end

endmodule

[bench/tb_worker_pool_autoscaler_core.sv]
// Self-checking testbench for worker_pool_autoscaler_core: directed ticks, then random ticks.
`timescale 1ns / 1ps

module tb_worker_pool_autoscaler_core;
  import wpa_pkg::*;

  localparam int TB = DEF_TIME_BITS;
  localparam int DB = DEF_DEPTH_BITS;
  localparam int WB = DEF_WORKER_BITS;
  localparam int ITEMS_PER_PHASE = 122;
  localparam int NUM_PHASES = 7;
  localparam longint unsigned STEP_CAP = 64'd1 << 40;
  localparam logic [TB-1:0] TIME_MAX = '1;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [TB-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic [TB-1:0] now_time;
  logic [DB-1:0] queue_depth;
  logic [WB-1:0] worker_count;
  logic out_valid;
  logic out_ready;
  logic [WB-1:0] target_workers;
  logic [1:0] pool_action;
  logic idle_applied;

  worker_pool_autoscaler_core u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .now_time(now_time),
    .queue_depth(queue_depth),
    .worker_count(worker_count),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .target_workers(target_workers),
    .pool_action(pool_action),
    .idle_applied(idle_applied)
  );

  // One expected result word per accepted tick.
  typedef struct {
    logic [WB-1:0] target;
    logic [1:0]    action;
    logic          idle;
  } pool_move_t;

  // Mirror of the autoscaler: register copies, idle/ramp tracking, and the
  // queue of pool moves still owed by the block.
  class autoscale_board;
    longint load_factor_r, busy_r, max_r, idle_r;
    logic [TB-1:0] idle_to, up_hold, down_hold;
    logic [DB-1:0] prev_depth;
    logic [TB-1:0] idle_since, last_change;
    bit tracking;
    logic [1:0] last_action;
    pool_move_t planned_moves[$];
    int fails;
    int seen;

    function new();
      load_factor_r = longint'(RST_LOAD_FACTOR[DB-1:0]);
      busy_r = longint'(RST_BUSY_WORKERS[WB-1:0]);
      max_r = longint'(RST_MAX_WORKERS[WB-1:0]);
      idle_r = longint'(RST_IDLE_WORKERS[WB-1:0]);
      idle_to = RST_IDLE_TIMEOUT[TB-1:0];
      up_hold = RST_RAMP_UP_HOLDOFF[TB-1:0];
      down_hold = RST_RAMP_DOWN_HOLDOFF[TB-1:0];
      prev_depth = '0;
      idle_since = '0;
      last_change = '0;
      tracking = 1'b1;     // queue starts out idle
      last_action = ACT_NONE;
      fails = 0;
      seen = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [TB-1:0] val);
      case (idx)
        CFG_LOAD_FACTOR:       load_factor_r = longint'(val[DB-1:0]);
        CFG_BUSY_WORKERS:      busy_r = longint'(val[WB-1:0]);
        CFG_MAX_WORKERS:       max_r = longint'(val[WB-1:0]);
        CFG_IDLE_WORKERS:      idle_r = longint'(val[WB-1:0]);
        CFG_IDLE_TIMEOUT:      idle_to = val;
        CFG_RAMP_UP_HOLDOFF:   up_hold = val;
        CFG_RAMP_DOWN_HOLDOFF: down_hold = val;
        default: ;
      endcase
    endfunction

    // Work out the move for one accepted tick and queue it.
    function void note_tick(logic [TB-1:0] now, logic [DB-1:0] depth, logic [WB-1:0] workers);
      longint load, tgt, span, over, nw;
      logic [TB-1:0] el;
      pool_move_t mv;
      nw = longint'(workers);
      load = (workers == 0) ? longint'(depth) : longint'(depth / workers);
      tgt = nw;
      mv.action = ACT_NONE;
      mv.idle = 1'b0;
      if (depth != 0) begin
        if (load <= load_factor_r) begin
          tgt = busy_r;
        end else if (load_factor_r == 0) begin
          tgt = max_r;
        end else begin
          // signed span; SV division truncates toward zero
          span = max_r - busy_r;
          over = load - load_factor_r;
          tgt = busy_r + (span * over) / load_factor_r;
        end
      end
      if (prev_depth != 0 && depth == 0) begin
        idle_since = now;
        tracking = 1'b1;
      end else if (prev_depth == 0 && depth == 0 && tracking) begin
        el = now - idle_since;
        if (el > idle_to) begin
          tgt = idle_r;
          mv.idle = 1'b1;
        end
      end else if (depth != 0) begin
        tracking = 1'b0;
      end
      // raise to idle floor first, then cap: the cap wins
      if (tgt < idle_r) tgt = idle_r;
      if (tgt > max_r) tgt = max_r;
      prev_depth = depth;
      el = now - last_change;
      if (tgt > nw && el > up_hold) begin
        mv.action = ACT_ADD;
        last_change = now;
      end else if (tgt < nw && el > down_hold) begin
        mv.action = ACT_REMOVE;
        last_change = now;
      end
      mv.target = tgt[WB-1:0];
      last_action = mv.action;
      planned_moves.push_back(mv);
    endfunction

    task report(string what);
      $display("ERROR: result %0d: %0s", seen, what);
      fails++;
    endtask

    task check_move(logic [WB-1:0] tgt, logic [1:0] act, logic idl);
      pool_move_t mv;
      if (planned_moves.size() == 0) begin
        report($sformatf("unexpected word target=%0d action=%0d idle=%0b", tgt, act, idl));
      end else begin
        mv = planned_moves.pop_front();
        if (tgt !== mv.target)
          report($sformatf("target_workers %0d, expected %0d", tgt, mv.target));
        if (act !== mv.action)
          report($sformatf("pool_action %0d, expected %0d", act, mv.action));
        if (idl !== mv.idle)
          report($sformatf("idle_applied %0b, expected %0b", idl, mv.idle));
      end
      seen++;
    endtask
  endclass

  autoscale_board sb;

  // sender pacing
  bit gaps_on;
  int burst_left;

  // stimulus state: running timestamp and the pool the "manager" believes in
  logic [TB-1:0] clock_t;
  int pool;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Hard stop in case the block hangs.
  initial begin
    #20_000_000;
    $display("tb_worker_pool_autoscaler_core: done, errors");
    $finish;
  end

  // Result monitor: a word moves when out_valid and out_ready meet at the edge.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_move(target_workers, pool_action, idle_applied);
  end

  // Receiver back-pressure. Modes change at random: always ready, light random stalls,
  // a fixed 3-in-7 low pattern, and long random stalls.
  initial begin
    int stall_left, mode, mode_left, phase_cnt;
    stall_left = 0;
    mode = 0;
    mode_left = 200;
    phase_cnt = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(100, 600);
      end else begin
        mode_left--;
      end
      phase_cnt = (phase_cnt == 6) ? 0 : phase_cnt + 1;
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        case (mode)
          0: out_ready <= 1'b1;
          1: begin
            if ($urandom_range(0, 7) == 0) begin
              out_ready <= 1'b0;
              stall_left = $urandom_range(0, 3);
            end else begin
              out_ready <= 1'b1;
            end
          end
          2: out_ready <= (phase_cnt >= 3);
          default: begin
            if ($urandom_range(0, 3) == 0) begin
              out_ready <= 1'b0;
              stall_left = $urandom_range(0, 29);
            end else begin
              out_ready <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  function automatic longint unsigned rand_upto(longint unsigned lim);
    longint unsigned r;
    r = {$urandom, $urandom};
    return r % (lim + 1);
  endfunction

  function automatic longint unsigned cap(logic [TB-1:0] x);
    return (longint'(x) > STEP_CAP) ? STEP_CAP : longint'(x);
  endfunction

  // Time step for a busy tick: sized around the holdoffs and the timeout.
  function automatic longint unsigned busy_step();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return rand_upto(cap(sb.up_hold) * 2 + 2);
    if (pick < 7) return rand_upto(cap(sb.down_hold) * 2 + 2);
    return rand_upto(cap(sb.idle_to) * 2 + 2);
  endfunction

  // Busy depth: often near the load factor threshold for this pool size.
  function automatic logic [DB-1:0] busy_depth(int w);
    int pick, d;
    pick = $urandom_range(0, 99);
    if (pick < 40)
      d = ((w == 0) ? 1 : w) * int'(sb.load_factor_r) + $urandom_range(0, 6) - 3;
    else if (pick < 75)
      d = $urandom_range(1, 64);
    else
      d = $urandom_range(1, 65535);
    if (d < 1) d = 1;
    if (d > 65535) d = 65535;
    return d[DB-1:0];
  endfunction

  // Present one tick word at a falling edge and hold it until taken.
  task automatic send_word(logic [TB-1:0] t, logic [DB-1:0] d, logic [WB-1:0] w);
    in_valid <= 1'b1;
    now_time <= t;
    queue_depth <= d;
    worker_count <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_tick(t, d, w);
    @(negedge clk);
    if (gaps_on) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 40)) @(negedge clk);
        burst_left = $urandom_range(1, 8);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Drop valid and wait for every owed word to come out.
  task automatic quiesce();
    in_valid <= 1'b0;
    while (sb.planned_moves.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Write all seven registers, one per cycle, while the block is idle.
  task automatic cfg_all(longint unsigned lf, longint unsigned busy, longint unsigned mx,
                         longint unsigned idl, longint unsigned tmo, longint unsigned up,
                         longint unsigned dn);
    logic [TB-1:0] vals[NUM_PHASES];
    logic [CFG_IDX_BITS-1:0] idx[NUM_PHASES];
    vals = '{TB'(lf), TB'(busy), TB'(mx), TB'(idl), TB'(tmo), TB'(up), TB'(dn)};
    idx = '{CFG_LOAD_FACTOR, CFG_BUSY_WORKERS, CFG_MAX_WORKERS, CFG_IDLE_WORKERS,
            CFG_IDLE_TIMEOUT, CFG_RAMP_UP_HOLDOFF, CFG_RAMP_DOWN_HOLDOFF};
    for (int i = 0; i < NUM_PHASES; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      sb.set_reg(idx[i], vals[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    bit idle_ep;
    int ep_left;
    logic [TB-1:0] t;
    logic [DB-1:0] d;
    logic [WB-1:0] w;
    sb = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_LOAD_FACTOR;
    cfg_data = '0;
    in_valid = 1'b0;
    now_time = '0;
    queue_depth = '0;
    worker_count = '0;
    gaps_on = 1'b1;
    burst_left = 2;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // --- directed ticks at reset register values ---
    send_word(48'd0, 16'd0, 8'd0);                 // idle queue, no workers
    send_word(48'd2_000_000, 16'd0, 8'd3);         // idle past timeout
    send_word(48'd2_000_100, 16'd10, 8'd0);        // zero workers: load is depth
    send_word(48'd2_010_000, 16'hFFFF, 8'hFF);     // deepest queue, biggest pool
    send_word(48'd2_200_000, 16'd8, 8'd2);         // load right at the factor
    send_word(48'd2_200_001, 16'd9, 8'd2);         // depth one over, load still at the factor
    send_word(48'd2_300_000, 16'd0, 8'd4);         // queue drains, idle timing starts
    send_word(48'd3_300_000, 16'd0, 8'd4);         // exactly the timeout: not yet
    send_word(48'd3_300_001, 16'd0, 8'd4);         // just past the timeout
    send_word(TIME_MAX, 16'd3, 8'd1);              // top of the time range
    send_word(48'd5, 16'd3, 8'd1);                 // time wraps around
    send_word(48'd1, 16'd0, 8'd1);                 // idle starts
    send_word(48'd0, 16'd0, 8'd1);                 // time goes backwards: huge elapsed

    // zero load factor, busy above max, idle floor above max, zero holdoffs
    quiesce();
    cfg_all(0, 200, 60, 70, 0, 0, 0);
    send_word(48'd4_000_000, 16'd1, 8'd1);
    send_word(48'd4_000_000, 16'd0, 8'd61);        // zero elapsed equals holdoff
    send_word(48'd4_000_001, 16'd0, 8'd61);

    // negative span with truncation toward zero, then a deep negative target
    quiesce();
    cfg_all(2, 10, 7, 0, 0, 0, 0);
    send_word(48'd4_000_010, 16'd5, 8'd1);
    send_word(48'd4_000_020, 16'd100, 8'd1);

    // --- random phases, each with its own register set ---
    clock_t = 48'd5_000_000;
    pool = 4;
    for (int p = 0; p < NUM_PHASES; p++) begin
      quiesce();
      case (p)
        0: cfg_all(4, 4, 16, 1, 1_000_000, 1000, 100_000);
        1: cfg_all(1, 0, 255, 0, 0, 0, 0);
        2: cfg_all(65535, 255, 255, 255, TIME_MAX, TIME_MAX, TIME_MAX);
        3: cfg_all(0, 8, 32, 2, 500, 100, 300);
        4: cfg_all(3, 20, 10, 40, 2000, 50, 50);
        5: cfg_all(2, 200, 60, 0, 10_000, 500, 5000);
        default: cfg_all($urandom_range(0, 12), $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 255), $urandom_range(0, 20_000),
                         $urandom_range(0, 20_000), $urandom_range(0, 20_000));
      endcase
      gaps_on = (p != 3);                          // one phase runs back to back
      idle_ep = 1'b0;
      ep_left = $urandom_range(1, 12);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ep_left == 0) begin
          idle_ep = !idle_ep;
          ep_left = idle_ep ? $urandom_range(1, 10) : $urandom_range(1, 12);
        end else begin
          ep_left--;
        end
        w = ($urandom_range(0, 99) < 15) ? WB'($urandom_range(0, 255)) : WB'(pool);
        if ($urandom_range(0, 99) < 6) begin
          // noise: arbitrary timestamp (may jump back), any depth and pool
          t = TB'({$urandom, $urandom});
          d = DB'($urandom);
          w = WB'($urandom);
        end else if (idle_ep) begin
          t = TB'(clock_t + rand_upto(cap(sb.idle_to) / 2 + 1));
          d = '0;
        end else begin
          t = TB'(clock_t + busy_step());
          d = busy_depth(int'(w));
        end
        clock_t = t;
        send_word(t, d, w);
        // follow the block's own request, as a real pool manager would
        pool = int'(w);
        if (sb.last_action == ACT_ADD && pool < 255) pool++;
        else if (sb.last_action == ACT_REMOVE && pool > 0) pool--;
      end
    end

    quiesce();
    repeat (60) @(negedge clk);                    // catch any stray extra word
    if (sb.fails == 0) begin
      $display("tb_worker_pool_autoscaler_core: done, clean");
    end else begin
      $display("tb_worker_pool_autoscaler_core: done, errors");
    end
    $finish;
  end

endmodule
